FILE: sv/rsfp_pkg.sv
// shared types and constants for the range sensor frame parser
package rsfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam int unsigned MEASURE_BYTES = 4;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUM   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type  frame_status;
      logic [7:0]  command_code;
      logic [7:0]  payload_length;
      logic [15:0] distance;
      logic [7:0]  strength;
      logic [7:0]  noise_level;
      logic        has_measurement;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } step_type;

   typedef struct packed {
      logic    emit;
      rsp_type word;
   } judge_type;

endpackage

FILE: sv/rsfp_stream_if.sv
// valid/ready channel interfaces for byte input and frame results
interface rsfp_req_if;
   import rsfp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rsfp_rsp_if;
   import rsfp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/rsfp_in_stage.sv
// input register holding one received byte
module rsfp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_byte,
   output logic               req_ready,
   input  logic               advance,
   output rsfp_pkg::step_type step
);
   import rsfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
      end
   end

   assign step.valid   = valid_ff;
   assign step.rx_byte = byte_ff;
endmodule

FILE: sv/rsfp_parser.sv
// frame state machine: header hunt, length check, checksum and field capture
module rsfp_parser #(
   parameter int unsigned MAX_PAYLOAD = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rsfp_pkg::step_type  step,
   input  logic                advance,
   output rsfp_pkg::judge_type judge
);
   import rsfp_pkg::*;

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] taken_ff, taken_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] measure_ff [MEASURE_BYTES];
   logic [7:0] measure_in [MEASURE_BYTES];
   logic [7:0] taken_next;
   logic [7:0] b;
   logic       show;

   assign b          = step.rx_byte;
   assign taken_next = taken_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      taken_in   = taken_ff;
      command_in = command_ff;
      measure_in = measure_ff;
      judge      = '0;
      show       = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (b == SYNC_FIRST) begin
               sum_in     = SYNC_FIRST;
               length_in  = '0;
               taken_in   = '0;
               command_in = '0;
               for (int i = 0; i < MEASURE_BYTES; i++) begin
                  measure_in[i] = '0;
               end
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               sum_in   = sum_ff + b;
               phase_in = PH_CMD;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CMD: begin
            command_in = b;
            sum_in     = sum_ff + b;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            length_in = b;
            sum_in    = sum_ff + b;
            if (b > MaxLen) begin
               judge.emit              = 1'b1;
               judge.word.frame_status = STATUS_TOO_LONG;
               phase_in                = PH_HUNT;
            end else if (b == 8'd0) begin
               phase_in = PH_SUM;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (taken_ff < 8'(MEASURE_BYTES)) begin
               measure_in[taken_ff[1:0]] = b;
            end
            sum_in   = sum_ff + b;
            taken_in = taken_next;
            if (taken_next >= length_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            phase_in   = PH_HUNT;
            sum_in     = '0;
            judge.emit = 1'b1;
            if (b == sum_ff) begin
               judge.word.frame_status = STATUS_GOOD;
               show                    = 1'b1;
            end else begin
               judge.word.frame_status = STATUS_BAD_SUM;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      judge.word.command_code   = command_in;
      judge.word.payload_length = length_in;
      if (show) begin
         judge.word.distance        = {measure_ff[1], measure_ff[0]};
         judge.word.strength        = measure_ff[2];
         judge.word.noise_level     = measure_ff[3];
         judge.word.has_measurement = (length_ff != 8'd0);
      end
      if (!step.valid) begin
         judge.emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         sum_ff     <= '0;
         length_ff  <= '0;
         taken_ff   <= '0;
         command_ff <= '0;
         for (int i = 0; i < MEASURE_BYTES; i++) begin
            measure_ff[i] <= '0;
         end
      end else if (step.valid && advance) begin
         phase_ff   <= phase_in;
         sum_ff     <= sum_in;
         length_ff  <= length_in;
         taken_ff   <= taken_in;
         command_ff <= command_in;
         measure_ff <= measure_in;
      end
   end
endmodule

FILE: sv/rsfp_out_stage.sv
// result register toward the response channel
module rsfp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  rsfp_pkg::judge_type judge,
   output logic                advance,
   output logic                rsp_valid,
   output rsfp_pkg::rsp_type   rsp_word,
   input  logic                rsp_ready
);
   import rsfp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? judge.emit : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && judge.emit) begin
         word_ff <= judge.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
endmodule

FILE: sv/range_sensor_frame_parser.sv
// top level of the range sensor frame parser
//
//   channel   dir   word                       handshake
//   req_if    in    one received serial byte   valid/ready
//   rsp_if    out   one judged frame result    valid/ready
//
// one byte per cycle while no waiting result stalls the parser; a byte is judged
// from the input register, and its result shows from the result register
// synchronous reset returns the parser to the header hunt with all state zero
// a waiting result stalls the parser; the input register still takes one byte
module range_sensor_frame_parser #(
   parameter int unsigned MAX_PAYLOAD = 16
) (
   input logic         clock,
   input logic         reset,
   rsfp_req_if.sink    req_if,
   rsfp_rsp_if.source  rsp_if
);
   import rsfp_pkg::*;

   step_type  step;
   judge_type judge;
   logic      advance;

   rsfp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_byte  (req_if.payload.rx_byte),
      .req_ready (req_if.ready),
      .advance   (advance),
      .step      (step)
   );

   rsfp_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .advance (advance),
      .judge   (judge)
   );

   rsfp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .judge     (judge),
      .advance   (advance),
      .rsp_valid (rsp_if.valid),
      .rsp_word  (rsp_if.payload),
      .rsp_ready (rsp_if.ready)
   );

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(step.valid))
      else $error("result appeared without a byte in the input register");

   a_measure_only_good: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.has_measurement |->
         rsp_if.payload.frame_status == STATUS_GOOD &&
         rsp_if.payload.payload_length != 8'd0)
      else $error("measurement flagged on a bad or empty frame");

   a_too_long_length: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.frame_status == STATUS_TOO_LONG |->
         rsp_if.payload.payload_length > 8'(MAX_PAYLOAD) &&
         rsp_if.payload.distance == 16'd0)
      else $error("length error with an acceptable length");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("input held off while the result register is empty");
endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the range sensor frame parser: directed table, then random frames
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rsfp_pkg::*;

   localparam int unsigned LEN_CAP       = 16;
   localparam int unsigned FRAME_BYTES   = 900;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned SHOWN_ERRORS  = 10;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      rsp_type    want;
   } row_type;

   logic clock;
   logic reset;

   rsfp_req_if req_if ();
   rsfp_rsp_if rsp_if ();

   range_sensor_frame_parser #(.MAX_PAYLOAD(LEN_CAP)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // parser state as the predictor sees it
   phase_type  frame_phase;
   logic [7:0] sum_so_far;
   logic [7:0] len_seen;
   logic [7:0] data_count;
   logic [7:0] cmd_seen;
   logic [7:0] meas [MEASURE_BYTES];

   rsp_type frames_due [$];
   row_type script [$];
   int      tally [3];
   int      mismatches;
   int      frame_bytes;
   int      stray_bytes;
   int      cycles;
   int      rsp_wait;
   int      settle;
   bit      calm;
   rsp_type got_want;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic rsp_type judged(input status_type st, input logic [7:0] cmd,
                                      input logic [7:0] len);
      rsp_type r;
      r = '0;
      r.frame_status   = st;
      r.command_code   = cmd;
      r.payload_length = len;
      return r;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output rsp_type res);
      bit done;
      done = 1'b0;
      res  = '0;
      case (frame_phase)
         PH_HUNT: begin
            if (b == SYNC_FIRST) begin
               sum_so_far = SYNC_FIRST;
               len_seen   = '0;
               data_count = '0;
               cmd_seen   = '0;
               foreach (meas[i]) meas[i] = '0;
               frame_phase = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               sum_so_far  = sum_so_far + b;
               frame_phase = PH_CMD;
            end else begin
               frame_phase = PH_HUNT;
            end
         end
         PH_CMD: begin
            cmd_seen    = b;
            sum_so_far  = sum_so_far + b;
            frame_phase = PH_LEN;
         end
         PH_LEN: begin
            len_seen   = b;
            sum_so_far = sum_so_far + b;
            if (b > LEN_CAP) begin
               res         = judged(STATUS_TOO_LONG, cmd_seen, b);
               done        = 1'b1;
               frame_phase = PH_HUNT;
            end else if (b == 0) begin
               frame_phase = PH_SUM;
            end else begin
               frame_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (data_count < MEASURE_BYTES) meas[data_count[1:0]] = b;
            sum_so_far = sum_so_far + b;
            data_count = data_count + 8'd1;
            if (data_count >= len_seen) frame_phase = PH_SUM;
         end
         PH_SUM: begin
            frame_phase = PH_HUNT;
            done        = 1'b1;
            if (b == sum_so_far) begin
               res                 = judged(STATUS_GOOD, cmd_seen, len_seen);
               res.distance        = {meas[1], meas[0]};
               res.strength        = meas[2];
               res.noise_level     = meas[3];
               res.has_measurement = (len_seen != 0);
            end else begin
               res = judged(STATUS_BAD_SUM, cmd_seen, len_seen);
            end
            sum_so_far = '0;
         end
         default: frame_phase = PH_HUNT;
      endcase
      return done;
   endfunction

   task automatic queue_frame(input rsp_type r);
      frames_due.push_back(r);
      tally[r.frame_status]++;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input rsp_type want);
      int      gap;
      rsp_type res;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.payload.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (parse_byte(b, res) && !typed) queue_frame(res);
      if (typed) queue_frame(want);
   endtask

   task automatic send_frame(input int len, input bit spoil, input int keep);
      logic [7:0] out_bytes [$];
      logic [7:0] sum;
      out_bytes.push_back(SYNC_FIRST);
      out_bytes.push_back(SYNC_SECOND);
      out_bytes.push_back(8'($urandom_range(0, 255)));
      out_bytes.push_back(8'(len));
      if (len <= LEN_CAP) begin
         repeat (len) out_bytes.push_back(8'($urandom_range(0, 255)));
         sum = '0;
         foreach (out_bytes[i]) sum = sum + out_bytes[i];
         if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
         out_bytes.push_back(sum);
      end
      foreach (out_bytes[i]) begin
         if (i < keep) begin
            send_byte(out_bytes[i], 1'b0, '0);
            frame_bytes++;
         end
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (frames_due.size() != 0);
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%s at cycle %0d", what, cycles);
         $display("  want st %0d cmd %h len %h dist %h str %h noise %h meas %b",
                  want.frame_status, want.command_code, want.payload_length,
                  want.distance, want.strength, want.noise_level, want.has_measurement);
         $display("  got  st %0d cmd %h len %h dist %h str %h noise %h meas %b",
                  got.frame_status, got.command_code, got.payload_length,
                  got.distance, got.strength, got.noise_level, got.has_measurement);
      end
   endtask

   task automatic add_row(input logic [7:0] b);
      row_type r;
      r.rx    = b;
      r.typed = 1'b0;
      r.want  = '0;
      script.push_back(r);
   endtask

   task automatic add_judged(input logic [7:0] b, input status_type st,
                             input logic [7:0] cmd, input logic [7:0] len);
      row_type r;
      r.rx    = b;
      r.typed = 1'b1;
      r.want  = judged(st, cmd, len);
      script.push_back(r);
   endtask

   // result side: random stalls, check every word against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait      <= 0;
         rsp_if.ready  <= 1'b1;
      end else if (rsp_if.valid && rsp_if.ready) begin
         settle = calm ? 0 : $urandom_range(0, 6);
         rsp_wait     <= settle;
         rsp_if.ready <= (settle == 0);
         if (frames_due.size() == 0) begin
            note_mismatch("result word with nothing expected", '0, rsp_if.payload);
         end else begin
            got_want = frames_due.pop_front();
            if (rsp_if.payload.frame_status    !== got_want.frame_status
                || rsp_if.payload.command_code    !== got_want.command_code
                || rsp_if.payload.payload_length  !== got_want.payload_length
                || rsp_if.payload.distance        !== got_want.distance
                || rsp_if.payload.strength        !== got_want.strength
                || rsp_if.payload.noise_level     !== got_want.noise_level
                || rsp_if.payload.has_measurement !== got_want.has_measurement) begin
               note_mismatch("result word mismatch", got_want, rsp_if.payload);
            end
         end
      end else if (rsp_wait > 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_if.ready <= (rsp_wait == 1);
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, frames_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int         pick;
      bit         paused;
      logic [7:0] b;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      reset          <= 1'b1;
      frame_phase = PH_HUNT;
      sum_so_far  = '0;
      len_seen    = '0;
      data_count  = '0;
      cmd_seen    = '0;
      foreach (meas[i]) meas[i] = '0;
      foreach (tally[i]) tally[i] = 0;
      mismatches  = 0;
      frame_bytes = 0;
      stray_bytes = 0;
      calm        = 1'b0;
      paused      = 1'b0;

      // stray byte while hunting, then bad second header that is not rescanned
      add_row(8'h00);
      add_row(SYNC_FIRST);
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      // length one above capacity
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'hFF);
      add_judged(8'h11, STATUS_TOO_LONG, 8'hFF, 8'h11);
      // zero length, good checksum
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'h00);
      add_row(8'h00);
      add_judged(8'hFF, STATUS_GOOD, 8'h00, 8'h00);
      // zero length, wrong checksum
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'h01);
      add_row(8'h00);
      add_judged(8'h01, STATUS_BAD_SUM, 8'h01, 8'h00);
      // short payload, upper measurement bytes read as zero
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'h80);
      add_row(8'h02);
      add_row(8'hFF);
      add_row(8'hFF);
      add_row(8'h7F);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_byte(script[i].rx, script[i].typed, script[i].want);
      drain();

      while (frame_bytes < FRAME_BYTES) begin
         calm = ($urandom_range(0, 4) == 0);
         if (!paused && frame_bytes >= FRAME_BYTES / 2) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_frame(($urandom_range(0, 7) == 0) ? LEN_CAP : $urandom_range(0, LEN_CAP),
                       ($urandom_range(0, 5) == 0), 1000);
         end else if (pick < 16) begin
            send_frame(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(LEN_CAP + 1, 255),
                       1'b0, 1000);
         end else if (pick < 18) begin
            send_frame($urandom_range(0, LEN_CAP), 1'b0, $urandom_range(1, 8));
         end else if (pick == 18) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_SECOND) b = SYNC_FIRST;
            send_byte(SYNC_FIRST, 1'b0, '0);
            send_byte(b, 1'b0, '0);
            frame_bytes += 2;
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
               stray_bytes++;
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d frame bytes and %0d stray bytes in %0d cycles",
               frame_bytes + script.size(), stray_bytes, cycles);
      $display("judged %0d good frames, %0d with bad checksum, %0d over length",
               tally[STATUS_GOOD], tally[STATUS_BAD_SUM], tally[STATUS_TOO_LONG]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/rsfp_pkg.sv
sv/rsfp_stream_if.sv
sv/rsfp_in_stage.sv
sv/rsfp_parser.sv
sv/rsfp_out_stage.sv
sv/range_sensor_frame_parser.sv
dv/tb_top.sv
